// File: rtl/ibpa_pkg.sv
// ----------------------------------------------------------------------------
// ibpa_pkg: shared types and constants
// Beat types, configuration record, queue entry and status records for the
// temporal bandpass amplifier.
// ----------------------------------------------------------------------------
package ibpa_pkg;

	localparam int COEFF_BITS  = 16;
	localparam int ADDR_W      = 20;
	localparam int LEVEL_W     = 4;
	localparam int CHAN_W      = 2;
	localparam int STORE_WORDS = 1 << ADDR_W;
	localparam int LP_W        = COEFF_BITS + 8;   // lowpass state, signed Q16.8
	localparam int GAIN_W      = 18;               // signed Q10.8 gain
	localparam int CFAC_W      = 17;               // unsigned Q1.16 channel factor
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CHAN_W-1:0] CHAN_LUMA = 2'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_FAST   = 3'd0,
		CFG_RATE_SLOW   = 3'd1,
		CFG_GAIN_CAP    = 3'd2,
		CFG_BASE_RATIO  = 3'd3,
		CFG_CHROMA_GAIN = 3'd4,
		CFG_LEVEL_COUNT = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] rate_fast;
		logic [15:0] rate_slow;
		logic [15:0] gain_cap;
		logic [23:0] base_ratio;
		logic [15:0] chroma_gain;
		logic [4:0]  level_count;
	} cfg_t;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] coeff_in;
		logic [LEVEL_W-1:0]           level_idx;
		logic [CHAN_W-1:0]            chan;
		logic [ADDR_W-1:0]            store_addr;
		logic                         first_frame;
	} in_item_t;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] amp_coeff;
		logic [ADDR_W-1:0]            out_addr;
		logic [LEVEL_W-1:0]           out_level;
		logic [CHAN_W-1:0]            out_chan;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  store_addr;
		logic [LEVEL_W-1:0] level_idx;
		logic [CHAN_W-1:0]  chan;
		logic               first_frame;
	} tag_t;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] coeff;
		tag_t                         tag;
		logic signed [GAIN_W-1:0]     gain;
		logic [CFAC_W-1:0]            cfac;
	} work_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
		logic               empty;
		logic               full;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

endpackage

// File: rtl/iir_bandpass_pyramid_amplifier.sv
// ----------------------------------------------------------------------------
// iir_bandpass_pyramid_amplifier: temporal bandpass and gain for pyramid data
// One pyramid coefficient per beat in, one amplified band coefficient out per update beat.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data, one coefficient per beat,
//                 tagged with level, channel, state address, first-frame flag.
//   out channel : out_valid / out_stall / out_data, amplified coefficient
//                 with the tags echoed. First-frame beats load the two
//                 lowpass states for their address and give no output beat.
//   cfg channel : cfg_valid / cfg_ready / cfg_index / cfg_data; always ready.
//                 Write only while the block is idle.
// Timing:
//   One beat per cycle sustained while the output is not stalled. An output beat
//   passes the queue write, then five back-end stages, then the output
//   register. The state store has one read and one write port; back-to-back
//   hits on one address are forwarded.
// Reset:
//   Control clears and config takes its default values. The state store is
//   not cleared: an address must see a first-frame beat before use.
// Stall:
//   An out_stall with a beat pending freezes the back end; the 4-entry
//   queue keeps taking input until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module iir_bandpass_pyramid_amplifier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ibpa_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ibpa_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ibpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ibpa_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ibpa_pkg::*;

	cfg_t       cfg_q;
	work_t      front_work;
	work_t      q_head;
	q_stat_t    q_stat;
	back_stat_t back_stat;
	logic       back_pop;

	// config is always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_fast   <= 16'd26214;
			cfg_q.rate_slow   <= 16'd3277;
			cfg_q.gain_cap    <= 16'd2560;
			cfg_q.base_ratio  <= 24'd65536;
			cfg_q.chroma_gain <= 16'd65535;
			cfg_q.level_count <= 5'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RATE_FAST:   cfg_q.rate_fast   <= cfg_data[15:0];
				CFG_RATE_SLOW:   cfg_q.rate_slow   <= cfg_data[15:0];
				CFG_GAIN_CAP:    cfg_q.gain_cap    <= cfg_data[15:0];
				CFG_BASE_RATIO:  cfg_q.base_ratio  <= cfg_data[23:0];
				CFG_CHROMA_GAIN: cfg_q.chroma_gain <= cfg_data[15:0];
				CFG_LEVEL_COUNT: cfg_q.level_count <= cfg_data[4:0];
				default: ;   // unmapped index, ignored
			endcase
		end
	end

	// front: gain and channel factor per beat
	ibpa_front u_front (
		.item (in_data),
		.cfg  (cfg_q),
		.work (front_work)
	);

	// input is held off only when the queue is full
	assign in_stall = q_stat.full;

	ibpa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid),
		.wdata  (front_work),
		.pop    (back_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	// back: state read-modify-write, filtering, scaling
	ibpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_stat.empty),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.pop       (back_pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (back_stat)
	);

	// back end must not drain the queue while its output is frozen
	a_no_pop_when_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !back_stat.pop)
		else $error("queue popped while output stalled");

	// an accepted beat always finds room in the queue
	a_accept_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (q_stat.count < Q_CNT_W'(Q_DEPTH)))
		else $error("beat accepted into a full queue");

	// a new result only comes from work that was in the pipeline
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_stat.busy))
		else $error("output beat without pipeline work");

endmodule

// File: rtl/ibpa_front.sv
// ----------------------------------------------------------------------------
// ibpa_front: item classification
// Works out the per-level gain and the channel factor for an incoming beat.
// ----------------------------------------------------------------------------
module ibpa_front (
	input  ibpa_pkg::in_item_t item,
	input  ibpa_pkg::cfg_t     cfg,
	output ibpa_pkg::work_t    work
);
	import ibpa_pkg::*;

	logic [4:0]         top_lvl;
	logic [4:0]         lvl;
	logic [4:0]         shamt;
	logic               no_gain;
	logic [23:0]        ratio;
	logic signed [26:0] gx;
	logic signed [26:0] cap;
	logic signed [26:0] gsel;

	always_comb begin
		top_lvl = (cfg.level_count >= 5'd1) ? cfg.level_count - 5'd1 : 5'd0;
		lvl     = {1'b0, item.level_idx};
		no_gain = (item.level_idx == '0) || (lvl >= top_lvl);
		shamt   = top_lvl - lvl;
		ratio   = cfg.base_ratio >> shamt;
		gx      = ($signed({3'b0, ratio}) - 27'sd256) <<< 1;
		cap     = $signed({11'b0, cfg.gain_cap});
		gsel    = (gx > cap) ? cap : gx;

		work.coeff            = item.coeff_in;
		work.tag.store_addr   = item.store_addr;
		work.tag.level_idx    = item.level_idx;
		work.tag.chan         = item.chan;
		work.tag.first_frame  = item.first_frame;
		work.gain             = no_gain ? '0 : gsel[GAIN_W-1:0];
		work.cfac             = (item.chan == CHAN_LUMA) ? CFAC_W'(17'h10000)
		                                                 : {1'b0, cfg.chroma_gain};
	end

endmodule

// File: rtl/ibpa_queue.sv
// ----------------------------------------------------------------------------
// ibpa_queue: work queue
// Short FIFO between the classification front and the filter back end.
// ----------------------------------------------------------------------------
module ibpa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ibpa_pkg::work_t    wdata,
	input  logic               pop,
	output ibpa_pkg::work_t    rdata,
	output ibpa_pkg::q_stat_t  stat
);
	import ibpa_pkg::*;

	work_t                entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + Q_CNT_W'(1);
				2'b01: count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/ibpa_back.sv
// ----------------------------------------------------------------------------
// ibpa_back: filter and gain pipeline
// State read-modify-write with forwarding, dual lowpass, band gain, chroma
// scaling, saturation and the output register.
// ----------------------------------------------------------------------------
module ibpa_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ibpa_pkg::work_t       head,
	input  logic                  q_empty,
	input  ibpa_pkg::cfg_t        cfg,
	input  logic                  out_stall,
	output logic                  pop,
	output logic                  out_valid,
	output ibpa_pkg::out_item_t   out_data,
	output ibpa_pkg::back_stat_t  stat
);
	import ibpa_pkg::*;

	localparam int P1_W = CFAC_W + LP_W + 1;        // rate * diff
	localparam int P3_W = LP_W + 1 + GAIN_W;        // band * gain
	localparam int T_W  = P3_W - 16;
	localparam int P4_W = T_W + CFAC_W + 1;         // t * channel factor
	localparam int R_W  = P4_W - 16;

	logic [2*LP_W-1:0] mem [STORE_WORDS];

	logic en;

	// stage 1
	logic              valid_s1;
	work_t             work_s1;
	logic [2*LP_W-1:0] rd_s1;
	// last write, for read-during-write forwarding
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [2*LP_W-1:0] lw_data_q;

	logic signed [LP_W-1:0] xs1, old1, old2;
	logic signed [LP_W:0]   d1, d2;
	logic signed [P1_W-1:0] prod1, prod2;

	// stage 2
	logic                   valid_s2;
	work_t                  work_s2;
	logic signed [LP_W-1:0] old1_s2, old2_s2;
	logic signed [P1_W-1:0] prod1_s2, prod2_s2;
	logic signed [P1_W-1:0] r1, r2;
	logic signed [LP_W-1:0] xs2, new1, new2;
	logic signed [LP_W:0]   band;

	// stage 3
	logic                   valid_s3;
	tag_t                   tag_s3;
	logic signed [LP_W:0]   band_s3;
	logic signed [GAIN_W-1:0] gain_s3;
	logic [CFAC_W-1:0]      cfac_s3;
	logic signed [P3_W-1:0] p3;

	// stage 4
	logic                   valid_s4;
	tag_t                   tag_s4;
	logic signed [P3_W-1:0] p_s4;
	logic [CFAC_W-1:0]      cfac_s4;
	logic signed [P3_W-1:0] t_full;
	logic signed [T_W-1:0]  t4;
	logic signed [P4_W-1:0] p4;

	// stage 5
	logic                   valid_s5;
	tag_t                   tag_s5;
	logic signed [P4_W-1:0] p_s5;
	logic signed [P4_W-1:0] r_full;
	logic signed [R_W-1:0]  r5;
	logic signed [COEFF_BITS-1:0] sat5;

	logic      out_valid_q;
	out_item_t out_data_q;

	// whole back end moves together; it only holds when a result is stuck
	assign en  = !(out_valid_q && out_stall);
	assign pop = en && !q_empty;

	// ---------------- state store ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1 <= mem[head.tag.store_addr];
			if (valid_s2) begin
				mem[work_s2.tag.store_addr] <= {new1, new2};
			end
		end
	end

	// ---------------- stage 1: forward and multiply ----------------
	always_comb begin
		xs1 = {work_s1.coeff, 8'b0};
		if (valid_s2 && work_s2.tag.store_addr == work_s1.tag.store_addr) begin
			old1 = new1;
			old2 = new2;
		end else if (lw_valid_q && lw_addr_q == work_s1.tag.store_addr) begin
			old1 = lw_data_q[2*LP_W-1:LP_W];
			old2 = lw_data_q[LP_W-1:0];
		end else begin
			old1 = rd_s1[2*LP_W-1:LP_W];
			old2 = rd_s1[LP_W-1:0];
		end
		d1    = {xs1[LP_W-1], xs1} - {old1[LP_W-1], old1};
		d2    = {xs1[LP_W-1], xs1} - {old2[LP_W-1], old2};
		prod1 = $signed({1'b0, cfg.rate_fast}) * d1;
		prod2 = $signed({1'b0, cfg.rate_slow}) * d2;
	end

	// ---------------- stage 2: state update and band ----------------
	always_comb begin
		xs2  = {work_s2.coeff, 8'b0};
		r1   = (prod1_s2 + P1_W'(32768)) >>> 16;
		r2   = (prod2_s2 + P1_W'(32768)) >>> 16;
		new1 = work_s2.tag.first_frame ? xs2 : old1_s2 + $signed(r1[LP_W-1:0]);
		new2 = work_s2.tag.first_frame ? xs2 : old2_s2 + $signed(r2[LP_W-1:0]);
		band = {new1[LP_W-1], new1} - {new2[LP_W-1], new2};
	end

	// ---------------- stages 3 to 5: gain, chroma, saturate ----------------
	always_comb begin
		p3     = band_s3 * gain_s3;
		t_full = (p_s4 + P3_W'(32768)) >>> 16;
		t4     = t_full[T_W-1:0];
		p4     = t4 * $signed({1'b0, cfac_s4});
		r_full = (p_s5 + P4_W'(32768)) >>> 16;
		r5     = r_full[R_W-1:0];
		if (r5 > R_W'(32767)) begin
			sat5 = 16'sh7FFF;
		end else if (r5 < -R_W'(32768)) begin
			sat5 = 16'sh8000;
		end else begin
			sat5 = r5[COEFF_BITS-1:0];
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1   <= head;
			lw_addr_q <= work_s2.tag.store_addr;
			lw_data_q <= {new1, new2};
			work_s2   <= work_s1;
			old1_s2   <= old1;
			old2_s2   <= old2;
			prod1_s2  <= prod1;
			prod2_s2  <= prod2;
			tag_s3    <= work_s2.tag;
			band_s3   <= band;
			gain_s3   <= work_s2.gain;
			cfac_s3   <= work_s2.cfac;
			tag_s4    <= tag_s3;
			p_s4      <= p3;
			cfac_s4   <= cfac_s3;
			tag_s5    <= tag_s4;
			p_s5      <= p4;
			out_data_q.amp_coeff <= sat5;
			out_data_q.out_addr  <= tag_s5.store_addr;
			out_data_q.out_level <= tag_s5.level_idx;
			out_data_q.out_chan  <= tag_s5.chan;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			lw_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			// last-write entry only holds data that really went to the store
			lw_valid_q  <= valid_s2;
			out_valid_q <= valid_s5 && !tag_s5.first_frame;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign stat.busy  = valid_s1 || valid_s2 || valid_s3 || valid_s4 || valid_s5;
	assign stat.pop   = pop;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the temporal bandpass pyramid amplifier
// Drives coefficient beats with bursty gaps against a randomly stalling
// receiver and checks each output beat against an in-bench lowpass/gain model.
// Config phases sweep the defaults, the extremes and random settings.
// ----------------------------------------------------------------------------
module tb_top;
	import ibpa_pkg::*;

	localparam int PHASE_ITEMS = 380;
	localparam int HOLD_CYCLES = 60;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	iir_bandpass_pyramid_amplifier u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---- model state: config copy and the two lowpass stores ----
	cfg_t      model_cfg;
	longint    fast_lp[int];
	longint    slow_lp[int];
	int        loaded_addr_q[$];     // addresses that have seen a first-frame beat
	out_item_t amp_expect_q[$];      // expected output beats, oldest first
	int        error_count;
	bit        hold_req;             // asks the receiver for one long hold-off
	int        burst_left;

	// round half up of v / 2^s
	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Updates the lowpass pair for one beat; returns 1 with the output beat
	// when the beat is not a first-frame load.
	function automatic bit bandpass_amplify(in_item_t it, output out_item_t res);
		longint xs, f, s, band, g, t, c, r;
		int a, top, lvl;
		a   = int'(it.store_addr);
		lvl = int'(it.level_idx);
		xs  = longint'(it.coeff_in) * 256;
		res = '0;
		if (it.first_frame) begin
			if (!fast_lp.exists(a))
				loaded_addr_q.push_back(a);
			fast_lp[a] = xs;
			slow_lp[a] = xs;
			return 1'b0;
		end
		f = fast_lp[a];
		s = slow_lp[a];
		f += round_q(longint'(model_cfg.rate_fast) * (xs - f), 16);
		s += round_q(longint'(model_cfg.rate_slow) * (xs - s), 16);
		fast_lp[a] = f;
		slow_lp[a] = s;
		band = f - s;
		// per-level gain, zero at the finest level and at/above the top one
		top = (model_cfg.level_count >= 1) ? model_cfg.level_count - 1 : 0;
		if (lvl == 0 || lvl >= top)
			g = 0;
		else begin
			g = 2 * (longint'(model_cfg.base_ratio >> (top - lvl)) - 256);
			if (g > longint'(model_cfg.gain_cap))
				g = model_cfg.gain_cap;
		end
		t = round_q(band * g, 16);
		c = (it.chan == CHAN_LUMA) ? 65536 : longint'(model_cfg.chroma_gain);
		r = round_q(t * c, 16);
		if (r > 32767)  r = 32767;
		if (r < -32768) r = -32768;
		res.amp_coeff = r[15:0];
		res.out_addr  = it.store_addr;
		res.out_level = it.level_idx;
		res.out_chan  = it.chan;
		return 1'b1;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		error_count++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	// ---- output monitor ----
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (amp_expect_q.size() == 0)
				report("unexpected beat, addr", out_data.out_addr, -1);
			else begin
				want = amp_expect_q.pop_front();
				if (out_data.amp_coeff !== want.amp_coeff)
					report("amp_coeff", $signed(out_data.amp_coeff),
						$signed(want.amp_coeff));
				if (out_data.out_addr !== want.out_addr)
					report("out_addr", out_data.out_addr, want.out_addr);
				if (out_data.out_level !== want.out_level)
					report("out_level", out_data.out_level, want.out_level);
				if (out_data.out_chan !== want.out_chan)
					report("out_chan", out_data.out_chan, want.out_chan);
			end
		end
	end

	// ---- receiver: stall pattern rotates through four modes, plus a long hold ----
	initial begin
		int cyc, hold_cnt;
		cyc = 0;
		hold_cnt = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				case ((cyc / 97) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= (cyc % 5 < 3);
				endcase
			end
		end
	end

	// ---- sender ----
	// Called at a falling edge; returns at the falling edge after acceptance.
	// A typed expectation overrides the model's value for that beat.
	task automatic send_beat(input in_item_t it, input bit typed = 0,
			input logic signed [15:0] typed_amp = '0);
		out_item_t res;
		int gap;
		if (burst_left == 0) begin
			// gap between bursts
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (bandpass_amplify(it, res)) begin
			if (typed)
				res.amp_coeff = typed_amp;
			amp_expect_q.push_back(res);
		end
		@(negedge clk);
	endtask

	// wait until every expected beat is out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (amp_expect_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// one register write; the caller drops cfg_valid after its last write
	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RATE_FAST:   model_cfg.rate_fast   = val[15:0];
			CFG_RATE_SLOW:   model_cfg.rate_slow   = val[15:0];
			CFG_GAIN_CAP:    model_cfg.gain_cap    = val[15:0];
			CFG_BASE_RATIO:  model_cfg.base_ratio  = val;
			CFG_CHROMA_GAIN: model_cfg.chroma_gain = val[15:0];
			CFG_LEVEL_COUNT: model_cfg.level_count = val[4:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] rf, input logic [15:0] rs,
			input logic [15:0] cap, input logic [23:0] base,
			input logic [15:0] cg, input logic [4:0] lc);
		write_reg(CFG_RATE_FAST, {8'b0, rf});
		write_reg(CFG_RATE_SLOW, {8'b0, rs});
		write_reg(CFG_GAIN_CAP, {8'b0, cap});
		write_reg(CFG_BASE_RATIO, base);
		write_reg(CFG_CHROMA_GAIN, {8'b0, cg});
		write_reg(CFG_LEVEL_COUNT, {19'b0, lc});
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t mk(input logic [15:0] x, input int lvl, input int ch,
			input int a, input bit ff);
		in_item_t it;
		it.coeff_in    = x;
		it.level_idx   = LEVEL_W'(lvl);
		it.chan        = CHAN_W'(ch);
		it.store_addr  = ADDR_W'(a);
		it.first_frame = ff;
		return it;
	endfunction

	// Random beats: mostly updates to loaded addresses, some fresh loads
	// (small pool or any address) and some reloads of a live one.
	task automatic random_phase(input int n, input bit with_pressure);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it = mk(16'($urandom), $urandom_range(0, 15), $urandom_range(0, 3), 0, 0);
			if (loaded_addr_q.size() == 0 || $urandom_range(0, 9) == 0) begin
				it.first_frame = 1'b1;
				it.store_addr  = ($urandom_range(0, 1)) ? ADDR_W'($urandom_range(0, 63))
				                                        : ADDR_W'($urandom);
			end else begin
				it.store_addr  = ADDR_W'(loaded_addr_q[$urandom_range(0,
					loaded_addr_q.size() - 1)]);
				it.first_frame = ($urandom_range(0, 19) == 0);
			end
			if (with_pressure && i == n / 3)
				hold_req = 1'b1;        // receiver holds off, sender keeps pushing
			if (with_pressure && i == 2 * n / 3)
				drain();                // sender waits for every result
			send_beat(it);
		end
	endtask

	typedef struct {
		in_item_t            item;
		bit                  typed;
		logic signed [15:0]  amp;
	} dir_row_t;

	dir_row_t dir_rows[$];

	initial begin
		error_count = 0;
		hold_req    = 1'b0;
		burst_left  = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_RATE_FAST;
		cfg_data    = '0;
		model_cfg.rate_fast   = 16'd26214;
		model_cfg.rate_slow   = 16'd3277;
		model_cfg.gain_cap    = 16'd2560;
		model_cfg.base_ratio  = 24'd65536;
		model_cfg.chroma_gain = 16'd65535;
		model_cfg.level_count = 5'd8;

		// directed beats: loads at the field extremes, then updates over
		// finest/top/out-of-range levels and every channel code
		dir_rows = '{
			'{mk(16'h7FFF, 0, 0, 0, 1), 0, 0},
			'{mk(16'h8000, 15, 3, 20'hFFFFF, 1), 0, 0},
			'{mk(16'h0000, 5, 1, 1, 1), 0, 0},
			'{mk(16'h8000, 0, 0, 0, 0), 1, 16'sd0},       // finest level: no gain
			'{mk(16'h7FFF, 7, 0, 20'hFFFFF, 0), 1, 16'sd0}, // top level at reset
			'{mk(16'h7FFF, 15, 2, 1, 0), 1, 16'sd0},      // above the top level
			'{mk(16'h8000, 3, 0, 0, 0), 0, 0},
			'{mk(16'h8000, 3, 1, 20'hFFFFF, 0), 0, 0},
			'{mk(16'h7FFF, 3, 2, 1, 0), 0, 0},
			'{mk(16'h7FFF, 6, 3, 0, 0), 0, 0},            // channel code three
			'{mk(16'h8000, 1, 0, 1, 0), 0, 0},
			'{mk(16'h1234, 4, 0, 20'hFFFFF, 1), 0, 0},    // reload a live address
			'{mk(16'h7FFF, 4, 0, 20'hFFFFF, 0), 0, 0},
			'{mk(16'h0001, 5, 1, 0, 0), 0, 0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].amp);
		random_phase(PHASE_ITEMS, 1'b1);
		drain();

		// all zero, level count below two
		write_all(16'd0, 16'd0, 16'd0, 24'd0, 16'd0, 5'd0);
		random_phase(PHASE_ITEMS, 1'b0);
		drain();

		// all at maximum: saturation territory
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 5'd16);
		foreach (dir_rows[i])
			if (!dir_rows[i].typed)
				send_beat(dir_rows[i].item);
		random_phase(PHASE_ITEMS, 1'b0);
		drain();

		// random settings, smallest in-range level count first
		write_all(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
			16'($urandom), 5'd2);
		random_phase(PHASE_ITEMS / 2, 1'b0);
		drain();
		for (int p = 0; p < 2; p++) begin
			write_all(16'($urandom), 16'($urandom_range(0, 8000)), 16'($urandom),
				24'($urandom_range(0, 24'hFFFFFF)), 16'($urandom),
				5'($urandom_range(2, 16)));
			random_phase(PHASE_ITEMS * 3 / 4, 1'b1);
			drain();
		end

		if (error_count == 0)
			$display("PASS iir_bandpass_pyramid_amplifier");
		else
			$display("FAIL iir_bandpass_pyramid_amplifier");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("FAIL iir_bandpass_pyramid_amplifier");
		$finish;
	end

endmodule
